### sv/ftr_pkg.sv
package ftr_pkg;

    localparam int unsigned FRAME_BYTES = 11;

    localparam logic [7:0] HDR_BYTE    = 8'hFF;
    localparam logic [7:0] CMD_DATA    = 8'h53;
    localparam logic [7:0] CMD_PUBLISH = 8'h54;

    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_PUBLISH  = 3'd1;
    localparam logic [2:0] KIND_RAW      = 3'd2;
    localparam logic [2:0] KIND_POLL     = 3'd3;
    localparam logic [2:0] KIND_COMPLETE = 3'd4;

    typedef logic [2:0] t_op;

    localparam t_op OP_FRAME = 3'd0;
    localparam t_op OP_RAW   = 3'd1;
    localparam t_op OP_POLL  = 3'd2;
    localparam t_op OP_DONE  = 3'd3;
    localparam t_op OP_NONE  = 3'd4;

    typedef struct packed {
        t_op                         op;
        logic [3:0]                  count;
        logic                        last;
        logic [FRAME_BYTES-1:0][7:0] bytes;
    } t_cmd;

endpackage

### sv/ftr_ram.sv
module ftr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

### sv/ftr_front.sv
module ftr_front
    import ftr_pkg::*;
(
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_field_id,
    input  logic [63:0] i_field_value,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_message_end,
    output t_cmd        o_cmd
);

    always_comb begin
        o_cmd       = '0;
        o_cmd.last  = i_message_end;
        unique case (i_kind)
            KIND_DATA: begin
                o_cmd.op       = OP_FRAME;
                o_cmd.count    = 4'(FRAME_BYTES);
                o_cmd.bytes[0] = HDR_BYTE;
                o_cmd.bytes[1] = CMD_DATA;
                o_cmd.bytes[2] = i_field_id;
                for (int i = 0; i < 8; i++) begin
                    o_cmd.bytes[3+i] = i_field_value[8*i +: 8];
                end
            end
            KIND_PUBLISH: begin
                o_cmd.op       = OP_FRAME;
                o_cmd.count    = 4'd2;
                o_cmd.bytes[0] = HDR_BYTE;
                o_cmd.bytes[1] = CMD_PUBLISH;
            end
            KIND_RAW: begin
                o_cmd.op       = OP_RAW;
                o_cmd.count    = 4'd1;
                o_cmd.bytes[0] = i_raw_byte;
            end
            KIND_POLL: begin
                o_cmd.op = OP_POLL;
            end
            KIND_COMPLETE: begin
                o_cmd.op = OP_DONE;
            end
            default: begin
                o_cmd.op = OP_NONE;
            end
        endcase
    end

endmodule

### sv/ftr_queue.sv
module ftr_queue
    import ftr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_data
);

    t_cmd       r_entry [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;
    logic       push;
    logic       pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_entry[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr  = push ? ~r_wr : r_wr;
        n_rd  = pop ? ~r_rd : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_entry[r_wr] <= i_data;
        end
    end

endmodule

### sv/ftr_back.sv
module ftr_back
    import ftr_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_status,
    output logic       o_burst_valid,
    output logic [7:0] o_burst_start,
    output logic [7:0] o_burst_length
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0]   DEPTH_W  = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_WRITE = 1'b1;

    logic          r_state;
    logic          n_state;
    t_cmd          r_cmd;
    t_cmd          n_cmd;
    logic [3:0]    r_idx;
    logic [3:0]    n_idx;
    logic [AW-1:0] r_wp;
    logic [AW-1:0] n_wp;
    logic [AW-1:0] r_rp;
    logic [AW-1:0] n_rp;
    logic          r_sending;
    logic          n_sending;
    logic [AW-1:0] r_burst;
    logic [AW-1:0] n_burst;
    logic          r_drop;
    logic          n_drop;
    logic          r_out_valid;
    logic          n_out_valid;
    logic          r_status;
    logic          n_status;
    logic          r_bvalid;
    logic          n_bvalid;
    logic [7:0]    r_bstart;
    logic [7:0]    n_bstart;
    logic [7:0]    r_blen;
    logic [7:0]    n_blen;

    logic          slot_free;
    logic          full;
    logic [AW-1:0] wp_next;
    logic [AW-1:0] pending;
    logic [AW:0]   rp_sum;
    logic          wr_en;
    logic [7:0]    wr_data;

    assign slot_free = !r_out_valid || !i_stall;
    assign wp_next   = (r_wp == LAST_IDX) ? '0 : r_wp + 1'b1;
    assign full      = (wp_next == r_rp);
    assign pending   = (r_wp >= r_rp) ? r_wp - r_rp : AW'(DEPTH_W - {1'b0, r_rp});
    assign rp_sum    = {1'b0, r_rp} + {1'b0, r_burst};

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_sending   = r_sending;
        n_burst     = r_burst;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && i_stall;
        n_status    = r_status;
        n_bvalid    = r_bvalid;
        n_bstart    = r_bstart;
        n_blen      = r_blen;
        o_cmd_pop   = 1'b0;
        wr_en       = 1'b0;
        wr_data     = i_cmd.bytes[0];

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && i_cmd.op == OP_FRAME) begin
                    if (!full) begin
                        o_cmd_pop = 1'b1;
                        wr_en     = 1'b1;
                        n_wp      = wp_next;
                        n_cmd     = i_cmd;
                        n_idx     = 4'd1;
                        n_state   = S_WRITE;
                    end else if (slot_free) begin
                        o_cmd_pop   = 1'b1;
                        n_out_valid = 1'b1;
                        n_status    = 1'b1;
                        n_bvalid    = 1'b0;
                        n_bstart    = 8'd0;
                        n_blen      = 8'd0;
                    end
                end else if (i_cmd_valid && slot_free) begin
                    o_cmd_pop   = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = 1'b0;
                    n_bvalid    = 1'b0;
                    n_bstart    = 8'd0;
                    n_blen      = 8'd0;
                    unique case (i_cmd.op)
                        OP_RAW: begin
                            if (r_drop) begin
                                n_status = 1'b1;
                                if (i_cmd.last) begin
                                    n_drop = 1'b0;
                                end
                            end else if (full) begin
                                n_status = 1'b1;
                                if (!i_cmd.last) begin
                                    n_drop = 1'b1;
                                end
                            end else begin
                                wr_en = 1'b1;
                                n_wp  = wp_next;
                            end
                        end
                        OP_POLL: begin
                            if (!r_sending && pending != '0) begin
                                n_sending = 1'b1;
                                n_burst   = pending;
                                n_bvalid  = 1'b1;
                                n_bstart  = 8'(r_rp);
                                n_blen    = 8'(pending);
                            end
                        end
                        OP_DONE: begin
                            if (r_sending) begin
                                n_rp      = (rp_sum == DEPTH_W) ? '0 : rp_sum[AW-1:0];
                                n_sending = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WRITE: begin
                wr_data = r_cmd.bytes[r_idx];
                if (full || r_idx == r_cmd.count - 4'd1) begin
                    if (slot_free) begin
                        if (!full) begin
                            wr_en = 1'b1;
                            n_wp  = wp_next;
                        end
                        n_out_valid = 1'b1;
                        n_status    = full;
                        n_bvalid    = 1'b0;
                        n_bstart    = 8'd0;
                        n_blen      = 8'd0;
                        n_state     = S_IDLE;
                    end
                end else begin
                    wr_en = 1'b1;
                    n_wp  = wp_next;
                    n_idx = r_idx + 4'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 4'd0;
            r_wp        <= '0;
            r_rp        <= '0;
            r_sending   <= 1'b0;
            r_burst     <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_wp        <= n_wp;
            r_rp        <= n_rp;
            r_sending   <= n_sending;
            r_burst     <= n_burst;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_bvalid <= n_bvalid;
        r_bstart <= n_bstart;
        r_blen   <= n_blen;
    end

    ftr_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (wr_data),
        .i_rd_addr (r_rp),
        .o_rd_data ()
    );

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_burst_valid  = r_bvalid;
    assign o_burst_start  = r_bstart;
    assign o_burst_length = r_blen;

endmodule

### sv/framed_tx_ring_with_burst_issue_unit.sv
// A word waits in a two-entry command queue. A raw byte, poll or completion reaches the
// output register on acceptance; a frame, once its bytes are written or the ring is full.
// Throughput is one ring byte per cycle through the single ring write port, but a frame's
// last byte and other words wait on a stalled output, and a frame holds up the next word.
// Reset clears the pointers, the sending and dropping flags and the queue; ring contents are
// not cleared and no clearing pass is run.
module framed_tx_ring_with_burst_issue_unit
    import ftr_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_field_id,
    input  logic [63:0] i_field_value,
    input  logic [7:0]  i_raw_byte,
    input  logic        i_message_end,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_status,
    output logic        o_burst_valid,
    output logic [7:0]  o_burst_start,
    output logic [7:0]  o_burst_length
);

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;

    ftr_front u_front (
        .i_kind        (i_kind),
        .i_field_id    (i_field_id),
        .i_field_value (i_field_value),
        .i_raw_byte    (i_raw_byte),
        .i_message_end (i_message_end),
        .o_cmd         (front_cmd)
    );

    ftr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    ftr_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (queue_valid),
        .i_cmd          (queue_cmd),
        .o_cmd_pop      (queue_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_burst_valid  (o_burst_valid),
        .o_burst_start  (o_burst_start),
        .o_burst_length (o_burst_length)
    );

    assign o_stall = queue_full;

endmodule
